/* rtl/core/mqpd_pkg.sv */
// Shared types and constants for the MQTT packet deframer.
// No dependencies; imported by mqpd_framer and mqtt_packet_deframer.
`timescale 1ns / 1ps
`default_nettype none

package mqpd_pkg;

   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned GroupBits   = 7;   // payload bits per length byte
   localparam int unsigned LenWidth    = 28;  // four groups of seven
   localparam int unsigned SizeWidth   = 29;  // remaining length + header bytes
   localparam int unsigned LenIdxWidth = 2;

   localparam logic [LenIdxWidth-1:0] LEN_IDX_LAST = 2'd3;  // fourth length byte

   typedef enum logic [2:0] {
      PH_TYPE   = 3'b001,
      PH_LENGTH = 3'b010,
      PH_BODY   = 3'b100
   } phase_type;

   typedef struct packed {
      logic [ByteWidth-1:0] out_byte;
      logic                 first_of_packet;
      logic                 in_length_field;
      logic                 last_of_packet;
      logic [SizeWidth-1:0] packet_size;
   } result_type;

endpackage

`default_nettype wire

/* rtl/core/mqpd_framer.sv */
// Framing state and per-byte classification logic.
// Depends on mqpd_pkg; state advances only when step_en is high.
`timescale 1ns / 1ps
`default_nettype none

module mqpd_framer (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    step_en,
   input  wire  [mqpd_pkg::ByteWidth-1:0]         data_byte,
   output mqpd_pkg::result_type                   result,
   output mqpd_pkg::phase_type                    phase
);
   import mqpd_pkg::*;

   phase_type                phase_ff,      phase_in;
   logic [LenWidth-1:0]      acc_ff,        acc_in;
   logic [LenIdxWidth-1:0]   len_idx_ff,    len_idx_in;
   logic [LenWidth-1:0]      bytes_left_ff, bytes_left_in;
   logic [SizeWidth-1:0]     total_ff,      total_in;

   logic [LenWidth-1:0]      group_shifted;
   logic [LenWidth-1:0]      acc_sum;
   logic [SizeWidth-1:0]     size_sum;
   logic [LenWidth-1:0]      left_dec;
   logic                     len_done;

   // Place the seven-bit group by its position in the field.
   always_comb begin
      unique case (len_idx_ff)
         2'd0:    group_shifted = {21'd0, data_byte[GroupBits-1:0]};
         2'd1:    group_shifted = {14'd0, data_byte[GroupBits-1:0], 7'd0};
         2'd2:    group_shifted = {7'd0, data_byte[GroupBits-1:0], 14'd0};
         default: group_shifted = {data_byte[GroupBits-1:0], 21'd0};
      endcase
   end

   assign acc_sum  = acc_ff + group_shifted;
   // packet size: remaining length plus type byte plus (index + 1) length bytes
   assign size_sum = {1'b0, acc_sum} + {{(SizeWidth-LenIdxWidth){1'b0}}, len_idx_ff}
                     + SizeWidth'(2);
   assign len_done = !data_byte[ByteWidth-1] || (len_idx_ff == LEN_IDX_LAST);
   assign left_dec = (bytes_left_ff != '0) ? bytes_left_ff - LenWidth'(1) : '0;

   always_comb begin
      phase_in      = phase_ff;
      acc_in        = acc_ff;
      len_idx_in    = len_idx_ff;
      bytes_left_in = bytes_left_ff;
      total_in      = total_ff;

      result.out_byte        = data_byte;
      result.first_of_packet = 1'b0;
      result.in_length_field = 1'b0;
      result.last_of_packet  = 1'b0;
      result.packet_size     = '0;

      unique case (phase_ff)
         PH_LENGTH: begin
            result.in_length_field = 1'b1;
            acc_in = acc_sum;
            if (len_done) begin
               total_in           = size_sum;
               result.packet_size = size_sum;
               len_idx_in         = '0;
               if (acc_sum == '0) begin
                  // empty payload: length byte closes the packet
                  result.last_of_packet = 1'b1;
                  phase_in              = PH_TYPE;
               end else begin
                  bytes_left_in = acc_sum;
                  phase_in      = PH_BODY;
               end
            end else begin
               len_idx_in = len_idx_ff + LenIdxWidth'(1);
            end
         end
         PH_BODY: begin
            result.packet_size = total_ff;
            bytes_left_in      = left_dec;
            if (left_dec == '0) begin
               result.last_of_packet = 1'b1;
               phase_in              = PH_TYPE;
            end
         end
         default: begin
            result.first_of_packet = 1'b1;
            phase_in      = PH_LENGTH;
            acc_in        = '0;
            len_idx_in    = '0;
            bytes_left_in = '0;
            total_in      = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_TYPE;
         acc_ff        <= '0;
         len_idx_ff    <= '0;
         bytes_left_ff <= '0;
         total_ff      <= '0;
      end else if (step_en) begin
         phase_ff      <= phase_in;
         acc_ff        <= acc_in;
         len_idx_ff    <= len_idx_in;
         bytes_left_ff <= bytes_left_in;
         total_ff      <= total_in;
      end
   end

   assign phase = phase_ff;

endmodule

`default_nettype wire

/* rtl/core/mqtt_packet_deframer.sv */
// Channel     | Dir | Payload
// req_*       | in  | tdata[7:0] data_byte
// rsp_*       | out | tdata[7:0] out_byte, tdata[36:8] packet_size; tuser[0] first,
//             |     | tuser[1] in length field; tlast last byte of packet
//
// One byte per clock sustained while the output is not stalled.
// Input register -> framer logic -> result register; each stage moves when the next
// one is empty or draining, so a byte is taken while a result waits to be taken.
// Synchronous active-high reset clears both stage valids and the framing state.
// Depends on mqpd_pkg and mqpd_framer.
`timescale 1ns / 1ps
`default_nettype none

module mqtt_packet_deframer (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [7:0] data_byte
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] out_byte, [36:8] packet_size, [39:37] zero
   output logic [1:0]  rsp_tuser,   // [0] first_of_packet, [1] in_length_field
   output logic        rsp_tlast    // last_of_packet
);
   import mqpd_pkg::*;

   logic                  in_valid_ff, in_valid_in;
   logic [ByteWidth-1:0]  in_byte_ff;
   logic                  out_valid_ff, out_valid_in;
   result_type            out_ff;
   result_type            step_result;
   phase_type             phase;
   logic                  out_open;
   logic                  advance;
   logic                  req_xfer;

   assign out_open   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_open;
   assign req_tready = !in_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;

   mqpd_framer u_framer (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .data_byte (in_byte_ff),
      .result    (step_result),
      .phase     (phase)
   );

   assign in_valid_in  = req_xfer || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_byte_ff <= req_tdata;
      end
      if (advance) begin
         out_ff <= step_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_ff.packet_size, out_ff.out_byte};
   assign rsp_tuser  = {out_ff.in_length_field, out_ff.first_of_packet};
   assign rsp_tlast  = out_ff.last_of_packet;

`ifndef NO_ASSERTIONS
   // A byte that closes a packet leaves the framer waiting for a type byte.
   a_last_returns_to_type: assert property (@(posedge clock) disable iff (reset)
      advance && step_result.last_of_packet |=> phase == PH_TYPE)
      else $error("framer not back at type byte after packet end");

   // A type byte always moves the framer into the length field.
   a_type_enters_length: assert property (@(posedge clock) disable iff (reset)
      advance && step_result.first_of_packet |=> phase == PH_LENGTH)
      else $error("type byte did not open length field");

   // Input stalls only when both stages hold data and the output is blocked.
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> in_valid_ff && out_valid_ff && !rsp_tready)
      else $error("input stalled with room in the pipeline");

   // A stage transfer always leaves a result pending at the output.
   a_advance_fills_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("result register empty after stage transfer");
`endif

endmodule

`default_nettype wire

/* test/tb.sv */
// Self-checking bench for mqtt_packet_deframer: streams bytes, predicts the
// per-byte packet marks and sizes, and compares every response transfer.
// Depends on mqpd_pkg and the deframer RTL.
`timescale 1ns / 1ps

module tb;
   import mqpd_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] data_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;           // [7:0] out_byte, [36:8] packet_size
   logic [1:0]  rsp_tuser;           // [0] first_of_packet, [1] in_length_field
   logic        rsp_tlast;           // last_of_packet

   mqtt_packet_deframer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // framing state of the predictor
   phase_type             frame_phase = PH_TYPE;
   logic [LenWidth-1:0]   remaining_len = '0;
   logic [1:0]            len_byte_idx = '0;
   logic [SizeWidth-1:0]  body_left = '0;
   logic [SizeWidth-1:0]  frame_size = '0;

   result_type  expected_marks[$];
   int unsigned mismatch_count = 0;
   int unsigned bytes_sent = 0;
   bit          idle_on = 1'b1;

   task automatic predict_marks(input logic [7:0] b, output result_type r);
      r = '0;
      r.out_byte = b;
      case (frame_phase)
         PH_LENGTH: begin
            r.in_length_field = 1'b1;
            remaining_len = remaining_len + (LenWidth'(b[6:0]) << (GroupBits * len_byte_idx));
            if (!b[7] || len_byte_idx == LEN_IDX_LAST) begin
               // field done: type byte + length bytes + remaining length
               frame_size = {1'b0, remaining_len} + SizeWidth'(len_byte_idx) + SizeWidth'(2);
               r.packet_size = frame_size;
               if (remaining_len == '0) begin
                  r.last_of_packet = 1'b1;
                  frame_phase = PH_TYPE;
               end else begin
                  body_left = {1'b0, remaining_len};
                  frame_phase = PH_BODY;
               end
               len_byte_idx = '0;
            end else begin
               len_byte_idx = len_byte_idx + 2'd1;
            end
         end
         PH_BODY: begin
            r.packet_size = frame_size;
            if (body_left != '0) body_left = body_left - 1'b1;
            if (body_left == '0) begin
               r.last_of_packet = 1'b1;
               frame_phase = PH_TYPE;
            end
         end
         default: begin
            r.first_of_packet = 1'b1;
            frame_phase = PH_LENGTH;
            remaining_len = '0;
            len_byte_idx = '0;
            body_left = '0;
            frame_size = '0;
         end
      endcase
   endtask

   // random gaps on about one item in nine keep the input idle ~22% of cycles
   function automatic int unsigned next_gap();
      if (idle_on && $urandom_range(99) < 11) return $urandom_range(1, 4);
      return 0;
   endfunction

   // gap cycles with tvalid low, then one transfer
   task automatic send_byte(input int unsigned gap, input logic [7:0] b);
      result_type r;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      predict_marks(b, r);
      expected_marks.push_back(r);
      bytes_sent++;
   endtask

   task automatic send_packet(input logic [7:0] kind, input int unsigned body_len,
                              input int unsigned len_bytes, input bit top_on_fourth);
      logic [7:0] lb;
      send_byte(next_gap(), kind);
      for (int i = 0; i < len_bytes; i++) begin
         lb = 8'((body_len >> (7 * i)) & 127);
         if (i < len_bytes - 1 || top_on_fourth) lb[7] = 1'b1;
         send_byte(next_gap(), lb);
      end
      for (int i = 0; i < body_len; i++) send_byte(next_gap(), 8'($urandom));
   endtask

   task automatic send_random_packet();
      int unsigned body_len, min_bytes, len_bytes, pick;
      pick = $urandom_range(99);
      if (pick < 70)      body_len = $urandom_range(0, 8);
      else if (pick < 95) body_len = $urandom_range(0, 40);
      else                body_len = $urandom_range(100, 300);
      min_bytes = (body_len < 128) ? 1 : 2;
      len_bytes = min_bytes;
      // non-minimal encodings padded with zero continuation groups
      if ($urandom_range(99) < 30) len_bytes = $urandom_range(min_bytes, 4);
      send_packet(8'($urandom), body_len, len_bytes,
                  (len_bytes == 4) ? 1'($urandom) : 1'b0);
   endtask

   task automatic test_empty_payload();
      send_byte(next_gap(), 8'h00);
      send_byte(next_gap(), 8'h00);
   endtask

   task automatic test_fourth_length_byte();
      // continuation bit on the fourth length byte is ignored
      send_packet(8'hFF, 0, 4, 1'b1);
   endtask

   task automatic test_payload_extremes();
      send_byte(next_gap(), 8'h30);
      send_byte(next_gap(), 8'h83);
      send_byte(next_gap(), 8'h00);
      send_byte(next_gap(), 8'h00);
      send_byte(next_gap(), 8'hFF);
      send_byte(next_gap(), 8'h55);
   endtask

   task automatic test_short_header();
      // length field stalls mid-way; deframer must just wait
      send_byte(next_gap(), 8'h82);
      send_byte(next_gap(), 8'h81);
      send_byte(16, 8'h80);
      send_byte(12, 8'h80);
      send_byte(next_gap(), 8'h00);
      send_byte(next_gap(), 8'hAA);
   endtask

   task automatic test_random_packets();
      while (bytes_sent < 400) send_random_packet();
   endtask

   task automatic test_back_to_back();
      idle_on = 1'b0;
      while (bytes_sent < 520) send_random_packet();
      idle_on = 1'b1;
   endtask

   always @(posedge clock) begin
      rsp_tready <= !idle_on || ($urandom_range(99) >= 22);
   end

   task automatic check_field(input string name, input logic [28:0] exp_v,
                              input logic [28:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_marks.size() == 0) begin
            $display("%0t: unexpected response transfer, expected none, actual %0h",
                     $time, rsp_tdata);
            mismatch_count++;
         end else begin
            e = expected_marks.pop_front();
            check_field("out_byte", 29'(e.out_byte), 29'(rsp_tdata[7:0]));
            check_field("first_of_packet", 29'(e.first_of_packet), 29'(rsp_tuser[0]));
            check_field("in_length_field", 29'(e.in_length_field), 29'(rsp_tuser[1]));
            check_field("last_of_packet", 29'(e.last_of_packet), 29'(rsp_tlast));
            check_field("packet_size", e.packet_size, rsp_tdata[36:8]);
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_payload();
      test_fourth_length_byte();
      test_payload_extremes();
      test_short_header();
      test_random_packets();
      test_back_to_back();
      req_tvalid <= 1'b0;
      while (expected_marks.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && expected_marks.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("timeout waiting for response transfers");
      $display("*** FAILED ***");
      $finish;
   end

endmodule

/* files.f */
rtl/core/mqpd_pkg.sv
rtl/core/mqpd_framer.sv
rtl/core/mqtt_packet_deframer.sv
test/tb.sv
